[rtl/core/pbms_pkg.sv]
// ============================================================================
// pbms_pkg
// Shared types and constants of the PWM buzzer melody sequencer.
// ============================================================================
`default_nettype none

package pbms_pkg;

  // Note table geometry.
  localparam int NOTE_AW        = 8;
  localparam int NOTE_DEPTH     = 1 << NOTE_AW;

  // Field widths.
  localparam int FREQ_W         = 16;
  localparam int BEATS_W        = 8;
  localparam int CNT_W          = 28;
  localparam int BEATMS_W       = 13;
  localparam int SONG_W         = 9;
  localparam int TICK_W         = 17;
  localparam int PROD_W         = BEATS_W + BEATMS_W;
  localparam int ENTRY_W        = FREQ_W + BEATS_W;
  localparam int DIV_CNT_W      = 5;

  // Beat length fixed point and timing constants.
  localparam int BEAT_FRAC_BITS = 4;
  localparam int GAP_TICKS      = 5;
  localparam int DUTY_DIV       = 5;

  // Duty compare as a reciprocal multiply: reload * ceil(2^30 / 5) >> 30.
  // The rounding error stays below one quotient step for any 28-bit reload,
  // so the result equals reload / 5 exactly.
  localparam int DUTY_SHIFT     = 30;
  localparam int DUTY_PROD_W    = 2 * CNT_W;
  localparam logic [CNT_W-1:0] DUTY_RECIP =
    CNT_W'(((1 << DUTY_SHIFT) + DUTY_DIV - 1) / DUTY_DIV);

  // Stream widths.
  localparam int IN_DATA_W      = 40;
  localparam int OUT_DATA_W     = 72;

  // Configuration register indexes.
  localparam logic [1:0] REG_COUNTER_FREQ = 2'd0;
  localparam logic [1:0] REG_BEAT_MS      = 2'd1;
  localparam logic [1:0] REG_NOTE_COUNT   = 2'd2;

  // Configuration reset values.
  localparam logic [CNT_W-1:0]    COUNTER_FREQ_RST = CNT_W'(1000000);
  localparam logic [BEATMS_W-1:0] BEAT_MS_RST      = BEATMS_W'(350);

  // Item kind carried on tuser.
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Playback phase.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_NOTE,
    PH_GAP
  } phase_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FETCH,
    ST_DIV_RELOAD,
    ST_DUTY,
    ST_DONE
  } seq_state_t;

endpackage : pbms_pkg

`default_nettype wire

[rtl/core/pwm_buzzer_melody_sequencer_unit.sv]
// ============================================================================
// pwm_buzzer_melody_sequencer_unit
// Plays a stored melody: note table in RAM, tick-driven note timing, a serial
// divider for the PWM reload and a reciprocal multiply for the 20% duty
// compare value.
// ============================================================================
//
//  Channel  Direction  Handshake            Contents
//  in_      slave      tvalid/tready        tick or note load, one beat each
//  out_     master     tvalid/tready        PWM state after each input beat
//  cfg_     write      cfg_we               counter_freq, beat_ms, note count
//
// A beat that changes no note runs the exec and done states; one that starts a
// rest adds the fetch state. A tone also runs the divider, one quotient bit per
// cycle for counter_freq/freq, then the duty state multiplies reload by 1/5.
// A new input beat is taken while the previous result still waits on out_;
// its own result then waits in the done state until out_ frees the register.
// Reset is synchronous and active low; the note table is not cleared.
// ============================================================================
`default_nettype none

module pwm_buzzer_melody_sequencer_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input stream.
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] motors_ok, [8:1] note_index, [24:9] note_freq, [32:25] note_beats
  input  wire logic [pbms_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] cmd
  input  wire logic                            in_tuser,
  // Result stream.
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [27:0] reload_value, [55:28] compare_value, [56] restart_counter,
  // [57] playing, [65:58] position
  output logic      [pbms_pkg::OUT_DATA_W-1:0] out_tdata,
  // Configuration.
  input  wire logic                            cfg_we,
  input  wire logic [1:0]                      cfg_index,
  input  wire logic [pbms_pkg::CNT_W-1:0]      cfg_wdata
);

  import pbms_pkg::*;

  // --------------------------------------------------------------------------
  // Declarations
  // --------------------------------------------------------------------------
  seq_state_t             state_r, state_nxt;

  logic [CNT_W-1:0]       counter_freq_r;
  logic [BEATMS_W-1:0]    beat_ms_r;
  logic [SONG_W-1:0]      song_len_r;

  logic [NOTE_AW-1:0]     pos_r,     pos_nxt;
  logic                   active_r,  active_nxt;
  phase_t                 phase_r,   phase_nxt;
  logic [TICK_W-1:0]      ticks_r,   ticks_nxt;
  logic [CNT_W-1:0]       reload_r,  reload_nxt;
  logic [CNT_W-1:0]       compare_r, compare_nxt;
  logic                   restart_r, restart_nxt;

  // Captured input beat.
  logic                   cmd_r;
  logic                   ok_r;
  logic [NOTE_AW-1:0]     idx_r;
  logic [FREQ_W-1:0]      freq_r;
  logic [BEATS_W-1:0]     beats_r;

  // Serial divider.
  logic [FREQ_W-1:0]      div_rem_r, div_rem_nxt;
  logic [CNT_W-1:0]       div_quo_r, div_quo_nxt;
  logic [FREQ_W-1:0]      div_den_r, div_den_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic [FREQ_W:0]        div_trial;
  logic                   div_ge;
  logic [FREQ_W-1:0]      div_rem_step;
  logic [CNT_W-1:0]       div_quo_step;
  logic                   div_last;

  // Duty compare product.
  logic [DUTY_PROD_W-1:0] duty_prod;

  // Output register.
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_load;

  // Note table port.
  logic                   ram_we;
  logic [NOTE_AW-1:0]     ram_addr;
  logic [ENTRY_W-1:0]     ram_wdata;
  logic [ENTRY_W-1:0]     ram_rdata;

  // Note start helpers.
  logic [FREQ_W-1:0]      note_freq;
  logic [BEATS_W-1:0]     note_beats;
  logic [PROD_W-1:0]      len_prod;
  logic [TICK_W-1:0]      len_raw;
  logic [TICK_W-1:0]      len_ticks;
  logic [TICK_W-1:0]      ticks_dec;
  logic [SONG_W-1:0]      pos_next;

  logic                   in_accept;

  assign in_accept = in_tvalid && in_tready;
  assign in_tready = (state_r == ST_IDLE);

  // --------------------------------------------------------------------------
  // Note table: entry holds {beats, freq}
  // --------------------------------------------------------------------------
  pbms_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NOTE_DEPTH)
  ) u_note_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign ram_wdata  = {beats_r, freq_r};
  assign note_freq  = ram_rdata[FREQ_W-1:0];
  assign note_beats = ram_rdata[ENTRY_W-1:FREQ_W];

  // Note length in ticks: beats * beat_ms without fraction, less the gap, at least one.
  assign len_prod  = PROD_W'(note_beats) * PROD_W'(beat_ms_r);
  assign len_raw   = TICK_W'(len_prod >> BEAT_FRAC_BITS);
  assign len_ticks = (len_raw > TICK_W'(GAP_TICKS + 1)) ? len_raw - TICK_W'(GAP_TICKS)
                                                        : TICK_W'(1);

  assign ticks_dec = (ticks_r != '0) ? ticks_r - TICK_W'(1) : ticks_r;
  assign pos_next  = SONG_W'(pos_r) + SONG_W'(1);

  // One restoring division step.
  assign div_trial    = {div_rem_r, div_quo_r[CNT_W-1]};
  assign div_ge       = (div_trial >= {1'b0, div_den_r});
  assign div_rem_step = div_ge ? FREQ_W'(div_trial - {1'b0, div_den_r})
                               : div_trial[FREQ_W-1:0];
  assign div_quo_step = {div_quo_r[CNT_W-2:0], div_ge};
  assign div_last     = (div_cnt_r == DIV_CNT_W'(CNT_W - 1));

  // Reload times the reciprocal of five; the upper bits are the duty compare.
  assign duty_prod = DUTY_PROD_W'(reload_r) * DUTY_PROD_W'(DUTY_RECIP);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        if (cmd_r == CMD_TICK && ok_r) begin
          if (phase_r == PH_GAP) begin
            if (ticks_dec == '0 && pos_next < song_len_r) begin
              state_nxt = ST_FETCH;
            end
          end else if (phase_r == PH_IDLE && active_r) begin
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = (note_freq == '0) ? ST_DONE : ST_DIV_RELOAD;
      end
      ST_DIV_RELOAD: begin
        if (div_last) begin
          state_nxt = ST_DUTY;
        end
      end
      ST_DUTY: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and outputs of the sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    pos_nxt     = pos_r;
    active_nxt  = active_r;
    phase_nxt   = phase_r;
    ticks_nxt   = ticks_r;
    reload_nxt  = reload_r;
    compare_nxt = compare_r;
    restart_nxt = restart_r;
    div_rem_nxt = div_rem_r;
    div_quo_nxt = div_quo_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    ram_we      = 1'b0;
    ram_addr    = pos_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          restart_nxt = 1'b0;
        end
      end
      ST_EXEC: begin
        if (cmd_r == CMD_LOAD) begin
          // Load only writes the table.
          ram_we   = 1'b1;
          ram_addr = idx_r;
        end else if (!ok_r) begin
          // Motors missing: abort play and silence.
          active_nxt  = 1'b0;
          phase_nxt   = PH_IDLE;
          ticks_nxt   = '0;
          compare_nxt = '0;
        end else if (phase_r == PH_NOTE) begin
          if (ticks_dec == '0) begin
            compare_nxt = '0;
            phase_nxt   = PH_GAP;
            ticks_nxt   = TICK_W'(GAP_TICKS);
          end else begin
            ticks_nxt = ticks_dec;
          end
        end else if (phase_r == PH_GAP) begin
          if (ticks_dec == '0) begin
            if (pos_next >= song_len_r) begin
              active_nxt = 1'b0;
              pos_nxt    = '0;
              phase_nxt  = PH_IDLE;
              ticks_nxt  = '0;
            end else begin
              // Advance and fetch the next note.
              pos_nxt   = pos_next[NOTE_AW-1:0];
              ram_addr  = pos_next[NOTE_AW-1:0];
              ticks_nxt = '0;
            end
          end else begin
            ticks_nxt = ticks_dec;
          end
        end
      end
      ST_FETCH: begin
        // Table entry is on the RAM output now: start the note.
        ticks_nxt = len_ticks;
        phase_nxt = PH_NOTE;
        if (note_freq == '0) begin
          compare_nxt = '0;
        end else begin
          restart_nxt = 1'b1;
          div_rem_nxt = '0;
          div_quo_nxt = counter_freq_r;
          div_den_nxt = note_freq;
          div_cnt_nxt = '0;
        end
      end
      ST_DIV_RELOAD: begin
        div_rem_nxt = div_rem_step;
        div_quo_nxt = div_quo_step;
        div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        if (div_last) begin
          reload_nxt = div_quo_step;
        end
      end
      ST_DUTY: begin
        // 20% duty compare from the new reload.
        compare_nxt = CNT_W'(duty_prod >> DUTY_SHIFT);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control and playback registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pos_r          <= '0;
      active_r       <= 1'b1;
      phase_r        <= PH_IDLE;
      ticks_r        <= '0;
      reload_r       <= '0;
      compare_r      <= '0;
      out_valid_r    <= 1'b0;
      counter_freq_r <= COUNTER_FREQ_RST;
      beat_ms_r      <= BEAT_MS_RST;
      song_len_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      active_r  <= active_nxt;
      phase_r   <= phase_nxt;
      ticks_r   <= ticks_nxt;
      reload_r  <= reload_nxt;
      compare_r <= compare_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_COUNTER_FREQ: counter_freq_r <= cfg_wdata;
          REG_BEAT_MS:      beat_ms_r      <= cfg_wdata[BEATMS_W-1:0];
          REG_NOTE_COUNT:   song_len_r     <= cfg_wdata[SONG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers: captured beat, divider, result
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r   <= in_tuser;
      ok_r    <= in_tdata[0];
      idx_r   <= in_tdata[8:1];
      freq_r  <= in_tdata[24:9];
      beats_r <= in_tdata[32:25];
    end
    restart_r <= restart_nxt;
    div_rem_r <= div_rem_nxt;
    div_quo_r <= div_quo_nxt;
    div_den_r <= div_den_nxt;
    div_cnt_r <= div_cnt_nxt;
    if (out_load) begin
      out_data_r <= {6'b0, pos_r, active_r, restart_r, compare_r, reload_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule : pwm_buzzer_melody_sequencer_unit

`default_nettype wire

[rtl/core/pbms_ram.sv]
// ============================================================================
// pbms_ram
// Generic single-port synchronous RAM with a registered read.
// ============================================================================
`default_nettype none

module pbms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write into the array; the registered read returns the old data on a write.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule : pbms_ram

`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: regression bench for pwm_buzzer_melody_sequencer_unit
//
// Loads note entries and sends millisecond ticks over the input stream. An
// in-bench model of the melody player follows every accepted beat and queues
// the PWM state that the block should report. Each result beat is checked
// field by field against the oldest queued state. Directed tests cover field
// extremes, rests, clamped note lengths, a zero counter clock and a long
// beat. Random phases then run with varied register settings and handshake
// stalls. The run closes with a motor fault that stops play.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbms_pkg::*;

  // PWM state reported for every input beat.
  typedef struct packed {
    logic [CNT_W-1:0] reload;
    logic [CNT_W-1:0] compare;
    logic             restart;
    logic             playing;
    logic [7:0]       position;
  } pwm_result_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tuser    = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we      = 1'b0;
  logic [1:0]            cfg_index   = REG_COUNTER_FREQ;
  logic [CNT_W-1:0]      cfg_wdata   = '0;

  // Handshake pressure, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // Largest note length in beats used for random note entries.
  int beats_cap     = 255;
  int mismatch_count = 0;

  // Player model: note table, play state and register copies.
  logic [FREQ_W-1:0]   tone_hz    [NOTE_DEPTH];
  logic [BEATS_W-1:0]  tone_beats [NOTE_DEPTH];
  bit                  entry_written [NOTE_DEPTH];
  logic [7:0]          note_pos;
  logic                song_on;
  phase_t              play_phase;
  logic [TICK_W-1:0]   ticks_to_go;
  logic [CNT_W-1:0]    reload_now;
  logic [CNT_W-1:0]    compare_now;
  logic [CNT_W-1:0]    cnt_hz;
  logic [BEATMS_W-1:0] ms_per_beat;
  logic [SONG_W-1:0]   song_notes;

  pwm_result_t pending_pwm_q[$];

  pwm_buzzer_melody_sequencer_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Starts the note at the current position; returns 1 for a tone.
  function automatic logic begin_note();
    logic [FREQ_W-1:0]  hz;
    logic [BEATS_W-1:0] bt;
    logic [PROD_W-1:0]  span;
    logic               hit;
    hz  = tone_hz[note_pos];
    bt  = tone_beats[note_pos];
    hit = 1'b0;
    if (hz == '0) begin
      compare_now = '0;
    end else begin
      reload_now  = cnt_hz / hz;
      compare_now = CNT_W'(reload_now / DUTY_DIV);
      hit         = 1'b1;
    end
    span = (PROD_W'(bt) * PROD_W'(ms_per_beat)) >> BEAT_FRAC_BITS;
    ticks_to_go = (span > GAP_TICKS + 1) ? TICK_W'(span - GAP_TICKS) : TICK_W'(1);
    play_phase = PH_NOTE;
    return hit;
  endfunction

  // Advances the player by one input beat and returns the state to report.
  function automatic pwm_result_t play_step(logic cmd, logic ok, logic [7:0] idx,
                                            logic [FREQ_W-1:0] hz, logic [BEATS_W-1:0] bt);
    pwm_result_t     r;
    logic            started;
    logic [SONG_W-1:0] nxt;
    started = 1'b0;
    if (cmd == CMD_LOAD) begin
      tone_hz[idx]       = hz;
      tone_beats[idx]    = bt;
      entry_written[idx] = 1'b1;
    end else if (!ok) begin
      // A motor fault stops play for good and silences the buzzer.
      song_on     = 1'b0;
      play_phase  = PH_IDLE;
      ticks_to_go = '0;
      compare_now = '0;
    end else if (play_phase == PH_NOTE) begin
      if (ticks_to_go != '0) ticks_to_go = ticks_to_go - 1'b1;
      if (ticks_to_go == '0) begin
        compare_now = '0;
        play_phase  = PH_GAP;
        ticks_to_go = TICK_W'(GAP_TICKS);
      end
    end else if (play_phase == PH_GAP) begin
      if (ticks_to_go != '0) ticks_to_go = ticks_to_go - 1'b1;
      if (ticks_to_go == '0) begin
        nxt = SONG_W'(note_pos) + 1'b1;
        if (nxt >= song_notes) begin
          song_on    = 1'b0;
          note_pos   = '0;
          play_phase = PH_IDLE;
        end else begin
          note_pos = nxt[7:0];
          started  = begin_note();
        end
      end
    end else if (song_on) begin
      started = begin_note();
    end
    r.reload   = reload_now;
    r.compare  = compare_now;
    r.restart  = started;
    r.playing  = song_on;
    r.position = note_pos;
    return r;
  endfunction

  // Table entry that the next good tick reads, or -1 if it reads none.
  function automatic int entry_needed();
    if (play_phase == PH_NOTE) return -1;
    if (play_phase == PH_GAP) begin
      if (ticks_to_go > 1) return -1;
      if (SONG_W'(note_pos) + 1'b1 >= song_notes) return -1;
      return (int'(note_pos) + 1) % NOTE_DEPTH;
    end
    return song_on ? int'(note_pos) : -1;
  endfunction

  function automatic logic [FREQ_W-1:0] random_hz();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return '0;
    if (pick < 25) return FREQ_W'($urandom_range(1, 16));
    return FREQ_W'($urandom);
  endfunction

  function automatic logic [BEATS_W-1:0] random_beats();
    if ($urandom_range(0, 1)) return BEATS_W'($urandom_range(0, beats_cap));
    return BEATS_W'($urandom_range(0, beats_cap / 5));
  endfunction

  // Sends one beat on the input stream and queues its expected result.
  task automatic send_item(logic cmd, logic ok, logic [7:0] idx,
                           logic [FREQ_W-1:0] hz, logic [BEATS_W-1:0] bt);
    int gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) gap++;
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= IN_DATA_W'({bt, hz, idx, ok});
    pending_pwm_q.push_back(play_step(cmd, ok, idx, hz, bt));
    do @(posedge clk); while (!in_tready);
  endtask

  // Sends a tick; loads the note it is about to read first if that entry is blank.
  task automatic send_tick(logic ok);
    int need;
    need = ok ? entry_needed() : -1;
    if (need >= 0 && !entry_written[need])
      send_item(CMD_LOAD, 1'($urandom), 8'(need), random_hz(), random_beats());
    send_item(CMD_TICK, ok, 8'($urandom), FREQ_W'($urandom), BEATS_W'($urandom));
  endtask

  task automatic tick_until(logic [7:0] target);
    while (!(note_pos == target && play_phase == PH_NOTE)) send_tick(1'b1);
  endtask

  // Stops sending and waits until every queued result has been seen.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_pwm_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] which, logic [CNT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (which)
      REG_COUNTER_FREQ: cnt_hz      = val;
      REG_BEAT_MS:      ms_per_beat = val[BEATMS_W-1:0];
      REG_NOTE_COUNT:   song_notes  = val[SONG_W-1:0];
      default: ;
    endcase
  endtask

  // First note plays with the reset register values.
  task automatic test_first_note();
    send_item(CMD_LOAD, 1'b1, 8'd0, 16'd440, 8'd0);
    send_tick(1'b1);
    drain();
    write_reg(REG_NOTE_COUNT, CNT_W'(256));
    write_reg(REG_COUNTER_FREQ, CNT_W'(268435455));
    write_reg(REG_BEAT_MS, CNT_W'(1));
  endtask

  // Lowest and highest tone, a rest, the longest beat count, the top index.
  task automatic test_field_extremes();
    send_item(CMD_LOAD, 1'b1, 8'd1, 16'd1, 8'd255);
    send_item(CMD_LOAD, 1'b0, 8'd2, 16'd0, 8'h80);
    send_item(CMD_LOAD, 1'b1, 8'd3, 16'hFFFF, 8'd0);
    send_item(CMD_LOAD, 1'b0, 8'd255, 16'hFFFF, 8'hFF);
    tick_until(8'd4);
  endtask

  // A zero counter clock gives zero reload and compare on a tone.
  task automatic test_zero_counter_freq();
    logic [7:0] tgt;
    drain();
    write_reg(REG_COUNTER_FREQ, '0);
    tgt = note_pos + 1'b1;
    send_item(CMD_LOAD, 1'b1, tgt, 16'd300, 8'h20);
    tick_until(tgt);
    drain();
    write_reg(REG_COUNTER_FREQ, CNT_W'(1000000));
  endtask

  // Largest beat length on a one-beat note, then a zero beat length.
  task automatic test_long_beat();
    logic [7:0] slow_pos;
    drain();
    send_idle_pct = 19;
    stall_pct     = 19;
    beats_cap     = 0;
    write_reg(REG_BEAT_MS, CNT_W'(8191));
    slow_pos = note_pos + 1'b1;
    send_item(CMD_LOAD, 1'b1, slow_pos, 16'd1000, 8'd1);
    send_item(CMD_LOAD, 1'b1, slow_pos + 8'd1, 16'd2000, 8'd0);
    tick_until(slow_pos + 8'd1);
    drain();
    write_reg(REG_BEAT_MS, '0);
    send_item(CMD_LOAD, 1'b1, slow_pos + 8'd2, 16'd3000, 8'd255);
    tick_until(slow_pos + 8'd2);
    beats_cap     = 255;
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Mostly ticks; loads land near the play position half of the time.
  task automatic run_random_phase(int count, int send_pct, int recv_pct,
                                  logic [CNT_W-1:0] hz_clock, logic [BEATMS_W-1:0] ms,
                                  logic [SONG_W-1:0] notes);
    logic [7:0] idx;
    drain();
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
    write_reg(REG_COUNTER_FREQ, hz_clock);
    write_reg(REG_BEAT_MS, CNT_W'(ms));
    write_reg(REG_NOTE_COUNT, CNT_W'(notes));
    repeat (count) begin
      if ($urandom_range(0, 99) < 30) begin
        idx = $urandom_range(0, 1) ? note_pos + 8'($urandom_range(1, 3)) : 8'($urandom);
        send_item(CMD_LOAD, 1'($urandom), idx, random_hz(), random_beats());
      end else begin
        send_tick(1'b1);
      end
    end
  endtask

  task automatic test_random_phases();
    run_random_phase(160, 0, 0, CNT_W'(268435455), 13'd1, 9'd256);
    run_random_phase(170, 77, 0, CNT_W'($urandom), 13'd2, 9'd255);
    run_random_phase(170, 0, 77, CNT_W'(1), 13'd0, 9'd256);
    run_random_phase(160, 19, 19, CNT_W'($urandom), 13'd4, 9'd255);
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  // Motor fault while a tone sounds; later beats must change nothing.
  task automatic test_motors_abort();
    logic [7:0] tgt;
    drain();
    write_reg(REG_BEAT_MS, CNT_W'(16));
    tgt = note_pos + 1'b1;
    send_item(CMD_LOAD, 1'b1, tgt, 16'd880, 8'h40);
    tick_until(tgt);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    repeat (3) send_tick(1'b1);
    send_tick(1'b0);
    send_item(CMD_LOAD, 1'b1, tgt, 16'd440, 8'h10);
    send_tick(1'b1);
  endtask

  // Receiver stalls.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Result check against the oldest queued state.
  always @(posedge clk) begin : check_results
    pwm_result_t want;
    pwm_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.reload   = out_tdata[27:0];
      got.compare  = out_tdata[55:28];
      got.restart  = out_tdata[56];
      got.playing  = out_tdata[57];
      got.position = out_tdata[65:58];
      if (pending_pwm_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result beat: reload %0d compare %0d restart %0b",
                   got.reload, got.compare, got.restart);
      end else begin
        want = pending_pwm_q.pop_front();
        if (got.reload !== want.reload || got.compare !== want.compare ||
            got.restart !== want.restart || got.playing !== want.playing ||
            got.position !== want.position) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch (expected/actual): reload %0d/%0d compare %0d/%0d",
                     want.reload, got.reload, want.compare, got.compare);
            $display("  restart %0b/%0b playing %0b/%0b position %0d/%0d",
                     want.restart, got.restart, want.playing, got.playing,
                     want.position, got.position);
          end
        end
      end
    end
  end

  initial begin
    // Model state after reset; the note table starts blank.
    foreach (entry_written[i]) entry_written[i] = 1'b0;
    note_pos    = '0;
    song_on     = 1'b1;
    play_phase  = PH_IDLE;
    ticks_to_go = '0;
    reload_now  = '0;
    compare_now = '0;
    cnt_hz      = COUNTER_FREQ_RST;
    ms_per_beat = BEAT_MS_RST;
    song_notes  = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_first_note();
    test_field_extremes();
    test_zero_counter_freq();
    test_long_beat();
    test_random_phases();
    test_motors_abort();

    drain();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && pending_pwm_q.size() == 0) begin
      $display("pwm_buzzer_melody_sequencer_unit regression: pass");
    end else begin
      $display("pwm_buzzer_melody_sequencer_unit regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("pwm_buzzer_melody_sequencer_unit regression: fail");
    $finish;
  end

endmodule
